// File: rtl/core/rpt_pkg.sv
package rpt_pkg;

    localparam int TABLE_DEPTH_DEF = 4;
    localparam int TABLE_DEPTH_MAX = 16;

    localparam logic [15:0]        HOP_EMPTY      = 16'hFFFF;
    localparam logic signed [15:0] RSSI_THR_RESET = -16'sd95;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 104;

    typedef struct packed {
        logic [15:0]        addr;
        logic [15:0]        seq;
        logic [15:0]        hop;
        logic signed [15:0] rssi;
    } entry_t;

    typedef enum logic [1:0] {
        CMD_BEACON     = 2'd0,
        CMD_INVALIDATE = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_IS_CONTROLLER  = 1'b0,
        CFG_RSSI_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_FILL,
        ST_SHIFT,
        ST_PUT,
        ST_DROP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        VERDICT_PASS,
        VERDICT_TAKE,
        VERDICT_DROP
    } verdict_t;

    function automatic entry_t empty_entry(input logic signed [15:0] thr);
        entry_t e;
        e.addr = 16'd0;
        e.seq  = 16'd0;
        e.hop  = HOP_EMPTY;
        e.rssi = thr;
        return e;
    endfunction

endpackage

// File: rtl/core/rpt_rank_cmp.sv
module rpt_rank_cmp (
    input  logic [15:0]          seq,
    input  logic [16:0]          hop1,
    input  logic signed [15:0]   rssi,
    input  logic signed [15:0]   thr,
    input  logic [15:0]          best_seq,
    input  rpt_pkg::entry_t      entry,
    output rpt_pkg::verdict_t    verdict
);
    import rpt_pkg::*;

    logic [16:0] entry_hop;

    assign entry_hop = {1'b0, entry.hop};

    // The first three checks do not depend on the entry, so they settle at entry 0.
    always_comb
    begin
        priority if (rssi < thr)
            verdict = VERDICT_DROP;
        else if (seq != 16'd0 && seq < best_seq)
            verdict = VERDICT_DROP;
        else if (seq != best_seq)
            verdict = VERDICT_TAKE;
        else if ((seq == 16'd0 && seq < entry.seq) || seq > entry.seq)
            verdict = VERDICT_TAKE;
        else if (hop1 > entry_hop)
            verdict = VERDICT_PASS;
        else if (hop1 == entry_hop && rssi <= entry.rssi)
            verdict = VERDICT_PASS;
        else
            verdict = VERDICT_TAKE;
    end

endmodule

// File: rtl/core/ranked_parent_table.sv
// Ranked parent table: holds TABLE_DEPTH candidate parents, best first, and
// processes one command per input transaction (beacon, invalidate best,
// timer tick, clear) with exactly one result transaction each. The table is
// a register file with one read port and one write port, walked by a small
// sequencer, one entry per cycle: a beacon takes its rank scan, a compaction
// pass over all entries, refill of freed tail slots, a shift to open its slot
// and a final write; a dropped beacon ends at the scan position where it
// stops, invalidate shifts the table up and refills the tail, clear refills
// every slot, and a tick or a beacon at the root goes straight to the result.
// The block takes no new command until the current one is finished, returns to
// idle before it accepts the next, and a result waits in the output register
// until taken.
module ranked_parent_table #(
    parameter int TABLE_DEPTH = rpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write: index 0 is_controller, 1 rssi_threshold
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sender_addr[15:0], seq_num[31:16], hop_num[47:32], rssi[63:48]
    input  logic [rpt_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted[0], rank[2:1], forward_request[3], send_beacon[4],
    // beacon_seq[20:5], beacon_hop[36:21], best_parent[52:37], best_hop[68:53],
    // best_seq[84:69], best_rssi[100:85], zero[103:101]
    output logic [rpt_pkg::M_DATA_W-1:0]  m_tdata
);
    import rpt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
    localparam logic [IW-1:0] PENULT = IW'(TABLE_DEPTH - 2);

    entry_t ptab_reg [TABLE_DEPTH];

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [15:0]        sender_reg, sender_next;
    logic [15:0]        seq_reg, seq_next;
    logic [16:0]        hop1_reg, hop1_next;
    logic signed [15:0] rssi_reg, rssi_next;
    logic [IW-1:0]      at_reg, at_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      w_reg, w_next;
    logic               acc_reg, acc_next;
    logic               fwd_reg, fwd_next;
    logic               send_reg, send_next;
    logic [15:0]        bseq_reg, bseq_next;
    logic [15:0]        bhop_reg, bhop_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic               is_ctrl_reg;
    logic signed [15:0] thr_reg;

    logic [IW-1:0]      rd_idx;
    entry_t             rd_entry;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    entry_t             wr_data;
    verdict_t           verdict;
    entry_t             new_entry;
    entry_t             best;
    logic               keep;
    logic [CW-1:0]      w_inc;
    logic [1:0]         rank_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign best     = ptab_reg[0];
    assign rd_entry = ptab_reg[rd_idx];
    assign keep     = (rd_entry.addr != sender_reg);
    assign w_inc    = w_reg + CW'(keep);
    assign rank_out = acc_reg ? 2'(at_reg) : 2'd0;

    always_comb
    begin
        new_entry.addr = sender_reg;
        new_entry.seq  = seq_reg;
        new_entry.hop  = hop1_reg[16] ? HOP_EMPTY : hop1_reg[15:0];
        new_entry.rssi = rssi_reg;
    end

    rpt_rank_cmp u_cmp (
        .seq      (seq_reg),
        .hop1     (hop1_reg),
        .rssi     (rssi_reg),
        .thr      (thr_reg),
        .best_seq (best.seq),
        .entry    (rd_entry),
        .verdict  (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_ctrl_reg <= 1'b0;
            thr_reg     <= RSSI_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IS_CONTROLLER:  is_ctrl_reg <= cfg_data[0];
                CFG_RSSI_THRESHOLD: thr_reg     <= cfg_data;
                default:            is_ctrl_reg <= is_ctrl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_DEPTH; k++)
            begin
                ptab_reg[k] <= empty_entry(RSSI_THR_RESET);
            end
        end
        else if (wr_en)
        begin
            ptab_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ptr_reg      <= '0;
            w_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ptr_reg      <= ptr_next;
            w_reg        <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        sender_reg  <= sender_next;
        seq_reg     <= seq_next;
        hop1_reg    <= hop1_next;
        rssi_reg    <= rssi_next;
        at_reg      <= at_next;
        acc_reg     <= acc_next;
        fwd_reg     <= fwd_next;
        send_reg    <= send_next;
        bseq_reg    <= bseq_next;
        bhop_reg    <= bhop_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        sender_next   = sender_reg;
        seq_next      = seq_reg;
        hop1_next     = hop1_reg;
        rssi_next     = rssi_reg;
        at_next       = at_reg;
        ptr_next      = ptr_reg;
        w_next        = w_reg;
        acc_next      = acc_reg;
        fwd_next      = fwd_reg;
        send_next     = send_reg;
        bseq_next     = bseq_reg;
        bhop_next     = bhop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_idx        = ptr_reg;
        wr_en         = 1'b0;
        wr_idx        = ptr_reg;
        wr_data       = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = cmd_t'(s_tuser);
                    sender_next = s_tdata[15:0];
                    seq_next    = s_tdata[31:16];
                    hop1_next   = {1'b0, s_tdata[47:32]} + 17'd1;
                    rssi_next   = s_tdata[63:48];
                    acc_next    = 1'b0;
                    fwd_next    = 1'b0;
                    send_next   = 1'b0;
                    bseq_next   = 16'd0;
                    bhop_next   = 16'd0;
                    ptr_next    = '0;
                    w_next      = '0;
                    unique case (cmd_t'(s_tuser))
                        CMD_BEACON:
                            state_next = is_ctrl_reg ? ST_DONE : ST_SCAN;
                        CMD_INVALIDATE:
                        begin
                            if (TABLE_DEPTH == 1)
                                state_next = ST_FILL;
                            else
                                state_next = ST_DROP;
                        end
                        CMD_TICK:
                        begin
                            send_next  = 1'b1;
                            bseq_next  = best.seq;
                            bhop_next  = best.hop;
                            // the root advances its own sequence on every tick
                            wr_en      = is_ctrl_reg;
                            wr_idx     = '0;
                            wr_data    = best;
                            wr_data.seq = best.seq + 16'd1;
                            state_next = ST_DONE;
                        end
                        CMD_CLEAR:
                            state_next = ST_FILL;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end

            ST_SCAN:
            begin
                unique case (verdict)
                    VERDICT_TAKE:
                    begin
                        at_next    = ptr_reg;
                        acc_next   = 1'b1;
                        fwd_next   = (ptr_reg == '0);
                        ptr_next   = '0;
                        w_next     = '0;
                        state_next = ST_COMPACT;
                    end
                    VERDICT_DROP:
                        state_next = ST_DONE;
                    VERDICT_PASS:
                    begin
                        if (ptr_reg == LAST)
                            state_next = ST_DONE;
                        else
                            ptr_next = ptr_reg + 1'b1;
                    end
                    default:
                        state_next = ST_DONE;
                endcase
            end

            // drop every entry of this sender, keep order; write index trails read index
            ST_COMPACT:
            begin
                wr_en  = keep;
                wr_idx = w_reg[IW-1:0];
                w_next = w_inc;
                if (ptr_reg == LAST)
                begin
                    if (w_inc == CW'(TABLE_DEPTH))
                    begin
                        ptr_next   = LAST;
                        state_next = (at_reg == LAST) ? ST_PUT : ST_SHIFT;
                    end
                    else
                        state_next = ST_FILL;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_idx  = w_reg[IW-1:0];
                wr_data = empty_entry(thr_reg);
                w_next  = w_reg + 1'b1;
                if (w_reg == CW'(TABLE_DEPTH - 1))
                begin
                    ptr_next = LAST;
                    if (cmd_reg == CMD_BEACON)
                        state_next = (at_reg == LAST) ? ST_PUT : ST_SHIFT;
                    else
                        state_next = ST_DONE;
                end
            end

            // open the slot at the insertion rank, walking down from the tail
            ST_SHIFT:
            begin
                rd_idx = ptr_reg - 1'b1;
                wr_en  = 1'b1;
                wr_idx = ptr_reg;
                if (rd_idx == at_reg)
                    state_next = ST_PUT;
                else
                    ptr_next = ptr_reg - 1'b1;
            end

            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_idx     = at_reg;
                wr_data    = new_entry;
                state_next = ST_DONE;
            end

            ST_DROP:
            begin
                rd_idx = ptr_reg + 1'b1;
                wr_en  = 1'b1;
                wr_idx = ptr_reg;
                if (ptr_reg == PENULT)
                begin
                    w_next     = CW'(TABLE_DEPTH - 1);
                    state_next = ST_FILL;
                end
                else
                    ptr_next = ptr_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, best.rssi, best.seq, best.hop, best.addr,
                                     bhop_reg, bseq_reg, send_reg, fwd_reg, rank_out,
                                     acc_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    a_fwd_needs_rank0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[3] || (m_tdata[0] && m_tdata[2:1] == 2'd0)))
        else $error("forward request without insertion at rank 0");

    a_send_excl_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[4] && m_tdata[0]))
        else $error("tick result also marks a beacon as accepted");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT) |-> (w_reg <= {1'b0, ptr_reg}))
        else $error("compaction write index passed read index");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted command did not start processing");

endmodule

// File: tb/ranked_parent_table_tb.sv
`timescale 1ns / 1ps

module ranked_parent_table_tb;
    import rpt_pkg::*;

    localparam int TBL_N       = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_CAP   = 200;

    // result fields, highest bits first
    typedef struct packed {
        logic [2:0]         pad;
        logic signed [15:0] best_rssi;
        logic [15:0]        best_seq;
        logic [15:0]        best_hop;
        logic [15:0]        best_parent;
        logic [15:0]        beacon_hop;
        logic [15:0]        beacon_seq;
        logic               send_beacon;
        logic               forward_request;
        logic [1:0]         rank;
        logic               accepted;
    } result_t;

    typedef int fld_t [10];

    class parent_sb;
        entry_t             tbl [TBL_N];
        bit                 ctrl;
        logic signed [15:0] thr;
        result_t            expq [$];
        int                 errors;
        int                 n_seen;
        string              names [10];

        function new();
            ctrl   = 1'b0;
            thr    = RSSI_THR_RESET;
            errors = 0;
            n_seen = 0;
            names  = '{"accepted", "rank", "forward_request", "send_beacon", "beacon_seq",
                       "beacon_hop", "best_parent", "best_hop", "best_seq", "best_rssi"};
            foreach (tbl[i])
                tbl[i] = blank();
        endfunction

        function entry_t blank();
            return '{16'd0, 16'd0, HOP_EMPTY, thr};
        endfunction

        function void set_reg(cfg_index_t idx, logic [15:0] v);
            if (idx == CFG_IS_CONTROLLER)
                ctrl = v[0];
            else
                thr = v;
        endfunction

        // Advance the table by one command and queue the result it must produce.
        function void note(cmd_t cmd, logic [15:0] addr, logic [15:0] seq,
                           logic [15:0] hop, logic signed [15:0] rssi);
            result_t     r;
            logic [16:0] hop1;
            int          at;
            int          w;
            bit          newer;
            entry_t      kept [TBL_N];
            r    = '0;
            hop1 = {1'b0, hop} + 17'd1;
            case (cmd)
                CMD_BEACON:
                begin
                    at = TBL_N;
                    if (!ctrl && rssi >= thr && !(seq != 16'd0 && seq < tbl[0].seq))
                    begin
                        if (seq != tbl[0].seq)
                            at = 0;
                        else
                        begin
                            // walk from the tail so the first qualifying slot wins
                            for (int i = TBL_N - 1; i >= 0; i--)
                            begin
                                newer = (seq == 16'd0 && tbl[i].seq != 16'd0) ||
                                        seq > tbl[i].seq;
                                if (newer || hop1 < tbl[i].hop ||
                                    (hop1 == tbl[i].hop && rssi > tbl[i].rssi))
                                    at = i;
                            end
                        end
                    end
                    if (at < TBL_N)
                    begin
                        w = 0;
                        foreach (tbl[i])
                        begin
                            if (tbl[i].addr != addr)
                            begin
                                kept[w] = tbl[i];
                                w++;
                            end
                        end
                        for (int i = w; i < TBL_N; i++)
                            kept[i] = blank();
                        for (int i = TBL_N - 1; i > at; i--)
                            kept[i] = kept[i - 1];
                        kept[at] = '{addr, seq, (hop1 > 17'hFFFF) ? HOP_EMPTY : hop1[15:0], rssi};
                        tbl = kept;
                        r.accepted        = 1'b1;
                        r.rank            = at[1:0];
                        r.forward_request = (at == 0);
                    end
                end
                CMD_INVALIDATE:
                begin
                    for (int i = 0; i < TBL_N - 1; i++)
                        tbl[i] = tbl[i + 1];
                    tbl[TBL_N - 1] = blank();
                end
                CMD_TICK:
                begin
                    r.send_beacon = 1'b1;
                    r.beacon_seq  = tbl[0].seq;
                    r.beacon_hop  = tbl[0].hop;
                    if (ctrl)
                        tbl[0].seq = tbl[0].seq + 16'd1;
                end
                default:
                begin
                    foreach (tbl[i])
                        tbl[i] = blank();
                end
            endcase
            r.best_parent = tbl[0].addr;
            r.best_hop    = tbl[0].hop;
            r.best_seq    = tbl[0].seq;
            r.best_rssi   = tbl[0].rssi;
            expq.push_back(r);
        endfunction

        function fld_t fields(result_t r);
            return '{int'(r.accepted), int'(r.rank), int'(r.forward_request),
                     int'(r.send_beacon), int'(r.beacon_seq), int'(r.beacon_hop),
                     int'(r.best_parent), int'(r.best_hop), int'(r.best_seq),
                     int'(r.best_rssi)};
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(result_t got);
            result_t want;
            fld_t    g;
            fld_t    w;
            n_seen++;
            if (expq.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", n_seen));
                return;
            end
            want = expq.pop_front();
            g = fields(got);
            w = fields(want);
            foreach (g[i])
            begin
                if (g[i] != w[i])
                    report($sformatf("result %0d %s: got %0d, expected %0d",
                                     n_seen, names[i], g[i], w[i]));
            end
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_IS_CONTROLLER;
    logic [15:0]           cfg_data  = 16'd0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [1:0]            s_tuser   = CMD_BEACON;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    parent_sb sb;
    bit       src_steady  = 1'b0;
    bit       sink_steady = 1'b0;

    ranked_parent_table #(
        .TABLE_DEPTH (TBL_N)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one command, hold it until taken, then idle for a random gap, if any.
    task automatic push_item(cmd_t cmd, logic [15:0] addr, logic [15:0] seq,
                             logic [15:0] hop, logic [15:0] rssi);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rssi, hop, seq, addr};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note(cmd, addr, seq, hop, rssi);
        gap = src_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expq.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back; the block is idle here.
    task automatic apply_setting(bit ctrl, logic [15:0] thr);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IS_CONTROLLER;
        cfg_data  <= {15'd0, ctrl};
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_IS_CONTROLLER, {15'd0, ctrl});
        cfg_index <= CFG_RSSI_THRESHOLD;
        cfg_data  <= thr;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(CFG_RSSI_THRESHOLD, thr);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int count);
        cmd_t        cmd;
        logic [15:0] addr;
        logic [15:0] seq;
        logic [15:0] hop;
        logic [15:0] rssi;
        int          pick;
        int          level;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                src_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 72)
                cmd = CMD_BEACON;
            else if (pick < 84)
                cmd = CMD_TICK;
            else if (pick < 96)
                cmd = CMD_INVALIDATE;
            else
                cmd = CMD_CLEAR;

            // small sender pool so duplicates and rank collisions are common
            pick = $urandom_range(0, 9);
            if (pick < 7)
                addr = 16'(pick + 1);
            else if (pick == 7)
                addr = 16'd0;
            else
                addr = 16'($urandom);

            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: seq = sb.tbl[0].seq;
                4:          seq = sb.tbl[0].seq + 16'd1;
                5:          seq = sb.tbl[0].seq + 16'($urandom_range(2, 5));
                6:          seq = sb.tbl[0].seq - 16'd1;
                7:          seq = 16'd0;
                default:    seq = 16'($urandom);
            endcase

            pick = $urandom_range(0, 9);
            if (pick < 7)
                hop = 16'($urandom_range(0, 6));
            else if (pick == 7)
                hop = 16'hFFFF;
            else if (pick == 8)
                hop = 16'hFFFE;
            else
                hop = 16'($urandom);

            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                level = $urandom_range(0, 48);
                level = level - 8 + sb.thr;
                if (level > 32767)
                    level = 32767;
                if (level < -32768)
                    level = -32768;
                rssi = 16'(level);
            end
            else if (pick == 7)
                rssi = 16'h7FFF;
            else if (pick == 8)
                rssi = 16'h8000;
            else
                rssi = 16'($urandom);

            push_item(cmd, addr, seq, hop, rssi);
        end
    endtask

    task automatic directed_items();
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_INVALIDATE, 16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_BEACON,     16'h0011, 16'd5, 16'd0, 16'(-40));
        // just below, then exactly at the threshold
        push_item(CMD_BEACON,     16'h0022, 16'd5, 16'd0, 16'(-96));
        push_item(CMD_BEACON,     16'h0022, 16'd5, 16'd0, 16'(-95));
        push_item(CMD_BEACON,     16'h0033, 16'd4, 16'd0, 16'd0);
        push_item(CMD_BEACON,     16'h0044, 16'd5, 16'd1, 16'(-20));
        push_item(CMD_BEACON,     16'h0055, 16'd5, 16'd0, 16'(-40));
        // full table, beacon worse than every entry
        push_item(CMD_BEACON,     16'h0066, 16'd5, 16'd3, 16'd0);
        push_item(CMD_BEACON,     16'h0044, 16'd5, 16'd0, 16'(-30));
        push_item(CMD_BEACON,     16'h0022, 16'd6, 16'd2, 16'(-90));
        // address zero collides with empty entries
        push_item(CMD_BEACON,     16'h0000, 16'd6, 16'd0, 16'd5);
        push_item(CMD_BEACON,     16'h0000, 16'd6, 16'd0, 16'd6);
        push_item(CMD_BEACON,     16'h0077, 16'd0, 16'd0, 16'(-10));
        push_item(CMD_BEACON,     16'h0088, 16'd0, 16'd5, 16'(-10));
        // hop count saturates
        push_item(CMD_BEACON,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        push_item(CMD_BEACON,     16'hFFFE, 16'hFFFF, 16'hFFFE, 16'h7FFF);
        push_item(CMD_BEACON,     16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_INVALIDATE, 16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_CLEAR,      16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_BEACON,     16'h1234, 16'h8000, 16'h7FFF, 16'h7FFE);
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        settle();

        apply_setting(1'b0, 16'h8000);
        random_items(300);
        settle();

        // seed a sequence near the top so the root's ticks wrap it
        src_steady = 1'b0;
        push_item(CMD_CLEAR,  16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_BEACON, 16'h0101, 16'hFFFE, 16'd2, 16'd0);
        settle();
        apply_setting(1'b1, 16'hFFA1);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_BEACON,     16'h0202, 16'd9, 16'd0, 16'd0);
        push_item(CMD_INVALIDATE, 16'h0000, 16'd0, 16'd0, 16'd0);
        push_item(CMD_TICK,       16'h0000, 16'd0, 16'd0, 16'd0);
        random_items(150);
        settle();

        apply_setting(1'b0, 16'h7FFF);
        random_items(250);
        settle();

        apply_setting(1'b0, 16'hFFC4);
        random_items(300);
        settle();

        apply_setting(1'b0, 16'hFFA1);
        random_items(300);
        settle();

        repeat (40) @(posedge clk);
        if (sb.expq.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expq.size()));
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, sometimes taken only once the result is waiting
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 1) == 1)
                begin
                    do
                        @(posedge clk);
                    while (!m_tvalid);
                end
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check(m_tdata);
            taken++;
            if (taken % 40 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // end the run if no transaction of any kind completes for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule
